// File: hw/rtl/wvpi_pkg.sv
// Shared types, constants and helpers for the wheel velocity PI controller.
`default_nettype none

package wvpi_pkg;

    localparam int DIN_W      = 104;
    localparam int DOUT_W     = 168;
    localparam int CMD_W      = 2;
    localparam int MODE_W     = 4;
    localparam int ENC_W      = 16;
    localparam int VAL_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int GAIN_W     = 24;
    localparam int ERR_W      = VAL_W + 1;
    localparam int MUL_A_W    = ERR_W + 1;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int FRAC_SHIFT = 8;
    localparam int SHR_W      = PROD_W - FRAC_SHIFT;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN_DT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VEL_PER_COUNT = 2'd2;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 24'd614400;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_DT_RST = 24'd7680;
    localparam logic [GAIN_W-1:0] VEL_PER_COUNT_RST = 24'd193020;

    localparam logic [MODE_W-1:0] MODE_DRIVE_A = 4'd1;
    localparam logic [MODE_W-1:0] MODE_DRIVE_B = 4'd2;
    localparam logic [MODE_W-1:0] MODE_DRIVE_C = 4'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAS,
        S_ERR,
        S_MULP,
        S_MULI,
        S_ACC,
        S_SUM,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_MEAS,
        MUL_PROP,
        MUL_INTEG
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     err_en;
        logic     p_en;
        logic     acc_en;
        logic     upd_en;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic tick_run;
        logic out_free;
    } t_dp_stat;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SHR_W-1:0] v);
        logic hi_same;
        hi_same = (&v[SHR_W-1:VAL_W-1]) || !(|v[SHR_W-1:VAL_W-1]);
        if (hi_same) begin
            return v[VAL_W-1:0];
        end else if (v[SHR_W-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [SHR_W-1:0] sext_val(input logic signed [VAL_W-1:0] v);
        return {{(SHR_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wvpi_ctrl.sv
// Sequencer for one item: measure, error, P, I, sum (enabled ticks only), result.
`default_nettype none

module wvpi_ctrl
    import wvpi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.mul_sel  = MUL_MEAS;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MEAS;
                end
            end
            S_MEAS: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MEAS;
                n_state       = S_ERR;
            end
            S_ERR: begin
                o_cmd.err_en = 1'b1;
                n_state      = i_stat.tick_run ? S_MULP : S_OUT;
            end
            S_MULP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PROP;
                n_state       = S_MULI;
            end
            S_MULI: begin
                o_cmd.p_en    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_INTEG;
                n_state       = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.upd_en = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_acc_follows_muli: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc_en |-> $past(o_cmd.p_en))
        else $error("accumulate without preceding P capture");

endmodule

`default_nettype wire

// File: hw/rtl/wvpi_dp.sv
// Datapath: config registers, shared multiplier, PI state and result register.
`default_nettype none

module wvpi_dp
    import wvpi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [GAIN_W-1:0]     i_cfg_data,
    input  wire logic [CMD_W-1:0]      i_in_user,
    input  wire logic [DIN_W-1:0]      i_in_data,
    input  wire logic                  i_m_tready,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_out_valid,
    output logic [DOUT_W-1:0]          o_out_data
);

    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [GAIN_W-1:0] r_vel_per_count;

    t_cmd                     r_cmd;
    logic signed [ENC_W-1:0]  r_avg;
    logic signed [ERR_W-1:0]  r_setpoint;
    logic [MODE_W-1:0]        r_mode;
    logic                     r_en;
    logic                     r_clr;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [VAL_W-1:0]  r_meas;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [VAL_W-1:0]  r_p;
    logic signed [VAL_W-1:0]  r_integ;
    logic signed [VAL_W-1:0]  r_sum;
    logic signed [VAL_W-1:0]  r_prop;
    logic signed [VAL_W-1:0]  r_drive;
    logic                     r_out_valid;
    logic [DOUT_W-1:0]        r_out_data;

    logic signed [ENC_W-1:0]   w_left;
    logic signed [ENC_W-1:0]   w_right;
    logic signed [VAL_W-1:0]   w_ramp;
    logic signed [VAL_W-1:0]   w_target;
    logic signed [ENC_W:0]     w_pair;
    logic signed [ENC_W:0]     w_half;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SHR_W-1:0]   w_shr;
    logic signed [VAL_W-1:0]   w_shr_sat;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [VAL_W-1:0]   w_base;
    logic signed [VAL_W-1:0]   w_integ;
    logic signed [VAL_W-1:0]   w_sum;
    logic                      w_drive_mode;

    assign w_left   = i_in_data[ENC_W-1:0];
    assign w_right  = i_in_data[2*ENC_W-1:ENC_W];
    assign w_ramp   = i_in_data[2*ENC_W+VAL_W-1:2*ENC_W];
    assign w_target = i_in_data[2*ENC_W+2*VAL_W-1:2*ENC_W+VAL_W];

    assign w_pair = {w_left[ENC_W-1], w_left} + {w_right[ENC_W-1], w_right};
    assign w_half = w_pair + {{ENC_W{1'b0}}, w_pair[ENC_W]};

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_MEAS: begin
                w_mul_a = {{(MUL_A_W-ENC_W){r_avg[ENC_W-1]}}, r_avg};
                w_mul_b = {1'b0, r_vel_per_count};
            end
            MUL_PROP: begin
                w_mul_a = {r_err[ERR_W-1], r_err};
                w_mul_b = {1'b0, r_prop_gain};
            end
            MUL_INTEG: begin
                w_mul_a = {r_err[ERR_W-1], r_err};
                w_mul_b = {1'b0, r_integ_gain};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod       = w_mul_a * w_mul_b;
    assign w_shr        = r_prod[PROD_W-1:FRAC_SHIFT];
    assign w_shr_sat    = sat32(w_shr);
    assign w_err        = r_setpoint - {w_shr_sat[VAL_W-1], w_shr_sat};
    assign w_base       = r_clr ? '0 : r_integ;
    assign w_integ      = sat32(sext_val(w_base) + w_shr);
    assign w_sum        = sat32(sext_val(r_p) + sext_val(r_integ));
    assign w_drive_mode = (r_mode == MODE_DRIVE_A) || (r_mode == MODE_DRIVE_B)
                          || (r_mode == MODE_DRIVE_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= PROP_GAIN_RST;
            r_integ_gain    <= INTEG_GAIN_DT_RST;
            r_vel_per_count <= VEL_PER_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_PROP_GAIN:     r_prop_gain     <= i_cfg_data;
                REG_INTEG_GAIN_DT: r_integ_gain    <= i_cfg_data;
                REG_VEL_PER_COUNT: r_vel_per_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= t_cmd'(i_in_user);
            r_avg      <= w_half[ENC_W:1];
            r_setpoint <= (w_ramp >= w_target) ? {w_target[VAL_W-1], w_target}
                                               : {w_ramp[VAL_W-1], w_ramp};
            r_mode     <= i_in_data[2*ENC_W+2*VAL_W+MODE_W-1:2*ENC_W+2*VAL_W];
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.err_en) begin
            r_meas <= w_shr_sat;
            r_err  <= w_err;
        end
        if (i_cmd.p_en) begin
            r_p <= w_shr_sat;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {{(DOUT_W-5*VAL_W-1){1'b0}}, r_en, r_meas, r_integ,
                           r_prop, r_sum, r_drive};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_clr   <= 1'b0;
            r_integ <= '0;
            r_sum   <= '0;
            r_prop  <= '0;
            r_drive <= '0;
        end else begin
            if (i_cmd.load) begin
                unique case (t_cmd'(i_in_user))
                    CMD_START: begin
                        r_en  <= 1'b1;
                        r_clr <= 1'b1;
                    end
                    CMD_STOP:  r_en  <= 1'b0;
                    CMD_CLEAR: r_clr <= 1'b1;
                    CMD_TICK: begin
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.acc_en) begin
                r_integ <= w_integ;
                r_clr   <= 1'b0;
            end
            if (i_cmd.upd_en) begin
                r_sum  <= w_sum;
                r_prop <= r_p;
                if (w_drive_mode) begin
                    r_drive <= w_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.tick_run = (r_cmd == CMD_TICK) && r_en;
    assign o_stat.out_free = !r_out_valid || i_m_tready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

    a_clr_drops_on_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr) |-> $past(i_cmd.acc_en))
        else $error("clear flag dropped outside accumulate");

    a_upd_only_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.upd_en |-> (r_en && r_cmd == CMD_TICK))
        else $error("PI update while loop disabled");

    a_drive_changes_on_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_drive) |-> $past(i_cmd.upd_en && w_drive_mode))
        else $error("drive term changed outside a drive-mode update");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten before taken");

endmodule

`default_nettype wire

// File: hw/rtl/wheel_velocity_pi_controller_top.sv
// Top level of the wheel velocity PI controller.
//
//  Channel  Dir  Handshake                     Payload
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: enc/ramp/target/mode, tuser: command
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: drive/sum/prop/integ/meas/running
//  cfg      in   i_cfg_valid/o_cfg_ready       i_cfg_addr, i_cfg_data (24 bit gains)
//
// Enabled control tick: measure, error, P, I, accumulate, sum, output, with the single
// shared 34x25 multiplier used in turn for speed, P and I. Other commands and disabled
// ticks: measure, error, output. One item in flight at a time.
// Synchronous active-low reset restores default gains and clears the loop enable and the
// integ, sum, prop and drive terms. A stalled result holds in the output register while
// the next input can be accepted. Config writes are always accepted.
`default_nettype none

module wheel_velocity_pi_controller_top
    import wvpi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] enc_left, [31:16] enc_right, [63:32] ramp_speed,
    // [95:64] target_speed, [99:96] control_mode, [103:100] zero
    input  wire logic [DIN_W-1:0]      s_axis_tdata,
    // [1:0] command
    input  wire logic [CMD_W-1:0]      s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [31:0] drive_term, [63:32] pi_sum, [95:64] prop_term, [127:96] integ_term,
    // [159:128] measured_speed, [160] running, [167:161] zero
    output logic [DOUT_W-1:0]          m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [GAIN_W-1:0]     i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    wvpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    wvpi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_m_tready  (m_axis_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
